/* rtl/dcrsm_pkg.sv */
// ----------------------------------------------------------------------------
// dcrsm_pkg
// Shared types and constants for the dual channel ratio stability monitor.
// ----------------------------------------------------------------------------
package dcrsm_pkg;

  localparam int RATIO_W    = 14;
  localparam int TICK_W     = 17;
  localparam int LIMIT_W    = 10;
  localparam int CFG_ADDR_W = 3;
  localparam int NUM_CH     = 2;
  localparam int NUM_TMR    = 3;
  localparam int PROD_W     = 24;

  localparam logic [LIMIT_W-1:0] BAND_SCALE = 10'd1000;

  localparam int TMR_SETTLE = 0;
  localparam int TMR_STABLE = 1;
  localparam int TMR_TOUT   = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SETTLE_TICKS  = 3'd0,
    CFG_STABLE_TICKS  = 3'd1,
    CFG_TIMEOUT_TICKS = 3'd2,
    CFG_WARN_LIMIT    = 3'd3,
    CFG_FAULT_LIMIT   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic settled;
    logic stable;
    logic fault;
    logic warn_alarm;
    logic fault_alarm;
  } ch_status_t;

endpackage

/* rtl/dual_channel_ratio_stability_monitor_core.sv */
// ----------------------------------------------------------------------------
// dual_channel_ratio_stability_monitor_core
// Two-channel setpoint/measurement monitor with settle, stable and timeout
// timers per channel; one word in per tick, one status word out per tick.
// ----------------------------------------------------------------------------
// Each accepted input word is one monitor tick. A word is held in an input
// register, evaluated combinationally against the channel state and written to
// the output register, from which the status word is offered; a new word is
// taken every cycle unless the output stalls. The per-tick state update (timers,
// flags, last setpoint) is written with the output register, which sets the rate
// of one word per cycle. Timers count ticks and saturate at TIMER_LIMIT; a tick
// value register above TIMER_LIMIT makes that wait endless. Band limits are in
// tenths of a percent of the setpoint, a limit of zero turns the band off.
module dual_channel_ratio_stability_monitor_core #(
  parameter int TIMER_LIMIT = 99990
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [dcrsm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [dcrsm_pkg::TICK_W-1:0]      cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dcrsm_pkg::RATIO_W-1:0]     in_set_one,
  input  logic [dcrsm_pkg::RATIO_W-1:0]     in_set_two,
  input  logic [dcrsm_pkg::RATIO_W-1:0]     in_meas_one,
  input  logic [dcrsm_pkg::RATIO_W-1:0]     in_meas_two,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_all_stable,
  output logic                              out_any_fault,
  output logic                              out_settled_one,
  output logic                              out_stable_one,
  output logic                              out_fault_one,
  output logic                              out_settled_two,
  output logic                              out_stable_two,
  output logic                              out_fault_two,
  output logic                              out_warn_alarm_one,
  output logic                              out_fault_alarm_one,
  output logic                              out_warn_alarm_two,
  output logic                              out_fault_alarm_two
);
  import dcrsm_pkg::*;

  localparam int TW    = $clog2(TIMER_LIMIT + 1);
  localparam int CMP_W = (TW > TICK_W) ? TW : TICK_W;
  localparam logic [TW-1:0] TMR_MAX = TW'(TIMER_LIMIT);

  // configuration
  logic [TICK_W-1:0]  settle_ticks_r, stable_ticks_r, timeout_ticks_r;
  logic [LIMIT_W-1:0] warn_limit_r, fault_limit_r;

  // input stage
  logic               in_vld_r;
  logic [RATIO_W-1:0] set_r  [NUM_CH];
  logic [RATIO_W-1:0] meas_r [NUM_CH];

  // channel state
  logic [RATIO_W-1:0] last_set_r  [NUM_CH];
  logic [RATIO_W-1:0] last_set_nxt[NUM_CH];
  logic               seen_r      [NUM_CH];
  logic               seen_nxt    [NUM_CH];
  logic [TW-1:0]      tmr_cnt_r   [NUM_CH][NUM_TMR];
  logic [TW-1:0]      tmr_cnt_nxt [NUM_CH][NUM_TMR];
  logic               tmr_run_r   [NUM_CH][NUM_TMR];
  logic               tmr_run_nxt [NUM_CH][NUM_TMR];
  ch_status_t         st_r        [NUM_CH];
  ch_status_t         st_nxt      [NUM_CH];

  // output stage
  logic               out_vld_r;
  ch_status_t         out_st_r    [NUM_CH];

  logic               advance;

  // band products
  logic [RATIO_W:0]   diff      [NUM_CH];
  logic [RATIO_W-1:0] dev_mag   [NUM_CH];
  logic [PROD_W-1:0]  dev_scaled[NUM_CH];
  logic [PROD_W-1:0]  warn_span [NUM_CH];
  logic [PROD_W-1:0]  fault_span[NUM_CH];
  logic               out_warn  [NUM_CH];
  logic               out_fault [NUM_CH];

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r  <= '0;
      stable_ticks_r  <= '0;
      timeout_ticks_r <= '0;
      warn_limit_r    <= '0;
      fault_limit_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_SETTLE_TICKS:  settle_ticks_r  <= cfg_wr_data;
        CFG_STABLE_TICKS:  stable_ticks_r  <= cfg_wr_data;
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wr_data;
        CFG_WARN_LIMIT:    warn_limit_r    <= cfg_wr_data[LIMIT_W-1:0];
        CFG_FAULT_LIMIT:   fault_limit_r   <= cfg_wr_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      set_r[0]  <= in_set_one;
      set_r[1]  <= in_set_two;
      meas_r[0] <= in_meas_one;
      meas_r[1] <= in_meas_two;
    end
  end

  // out of band iff |meas - set| * 1000 > set * limit, limit nonzero
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      diff[c]       = {1'b0, meas_r[c]} - {1'b0, set_r[c]};
      dev_mag[c]    = diff[c][RATIO_W] ? RATIO_W'(-diff[c]) : diff[c][RATIO_W-1:0];
      dev_scaled[c] = PROD_W'(dev_mag[c]) * PROD_W'(BAND_SCALE);
      warn_span[c]  = PROD_W'(set_r[c]) * PROD_W'(warn_limit_r);
      fault_span[c] = PROD_W'(set_r[c]) * PROD_W'(fault_limit_r);
      out_warn[c]   = (warn_limit_r != '0) && (dev_scaled[c] > warn_span[c]);
      out_fault[c]  = (fault_limit_r != '0) && (dev_scaled[c] > fault_span[c]);
    end
  end

  always_comb begin
    logic go;
    logic oob;
    go  = 1'b0;
    oob = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      last_set_nxt[c]       = last_set_r[c];
      seen_nxt[c]           = seen_r[c];
      st_nxt[c]             = st_r[c];
      st_nxt[c].warn_alarm  = 1'b0;
      st_nxt[c].fault_alarm = 1'b0;
      for (int k = 0; k < NUM_TMR; k++) begin
        tmr_run_nxt[c][k] = tmr_run_r[c][k];
        if (tmr_run_r[c][k] && (tmr_cnt_r[c][k] < TMR_MAX)) begin
          tmr_cnt_nxt[c][k] = tmr_cnt_r[c][k] + 1'b1;
        end else begin
          tmr_cnt_nxt[c][k] = tmr_cnt_r[c][k];
        end
      end

      if (!seen_r[c] || (last_set_r[c] != set_r[c])) begin
        seen_nxt[c]                = 1'b1;
        last_set_nxt[c]            = set_r[c];
        tmr_cnt_nxt[c][TMR_SETTLE] = '0;
        tmr_run_nxt[c][TMR_SETTLE] = 1'b1;
        tmr_cnt_nxt[c][TMR_STABLE] = '0;
        tmr_run_nxt[c][TMR_STABLE] = 1'b0;
        tmr_cnt_nxt[c][TMR_TOUT]   = '0;
        tmr_run_nxt[c][TMR_TOUT]   = 1'b0;
        st_nxt[c].settled          = 1'b0;
        st_nxt[c].stable           = 1'b0;
        st_nxt[c].fault            = 1'b0;
      end else begin
        go = 1'b1;
        if (!st_r[c].settled) begin
          if (CMP_W'(settle_ticks_r) > CMP_W'(tmr_cnt_nxt[c][TMR_SETTLE])) begin
            go = 1'b0;
          end else begin
            tmr_cnt_nxt[c][TMR_SETTLE] = '0;
            tmr_run_nxt[c][TMR_SETTLE] = 1'b0;
            st_nxt[c].settled          = 1'b1;
          end
        end
        if (go) begin
          oob = out_warn[c] || out_fault[c];
          if (oob) begin
            if (tmr_cnt_nxt[c][TMR_TOUT] == '0) begin
              tmr_run_nxt[c][TMR_TOUT] = 1'b1;
            end
            if (CMP_W'(timeout_ticks_r) <= CMP_W'(tmr_cnt_nxt[c][TMR_TOUT])) begin
              st_nxt[c].warn_alarm     = out_warn[c];
              st_nxt[c].fault_alarm    = out_fault[c];
              tmr_cnt_nxt[c][TMR_TOUT] = '0;
              tmr_run_nxt[c][TMR_TOUT] = 1'b0;
              st_nxt[c].fault          = 1'b1;
            end
            tmr_cnt_nxt[c][TMR_STABLE] = '0;
            tmr_run_nxt[c][TMR_STABLE] = 1'b0;
            st_nxt[c].stable           = 1'b0;
          end else begin
            if (tmr_cnt_nxt[c][TMR_STABLE] == '0) begin
              tmr_run_nxt[c][TMR_STABLE] = 1'b1;
            end
            if (CMP_W'(stable_ticks_r) <= CMP_W'(tmr_cnt_nxt[c][TMR_STABLE])) begin
              tmr_cnt_nxt[c][TMR_STABLE] = '0;
              tmr_run_nxt[c][TMR_STABLE] = 1'b0;
              st_nxt[c].stable           = 1'b1;
            end
            tmr_cnt_nxt[c][TMR_TOUT] = '0;
            tmr_run_nxt[c][TMR_TOUT] = 1'b0;
            st_nxt[c].fault          = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        last_set_r[c] <= '0;
        seen_r[c]     <= 1'b0;
        st_r[c]       <= '0;
        for (int k = 0; k < NUM_TMR; k++) begin
          tmr_cnt_r[c][k] <= '0;
          tmr_run_r[c][k] <= 1'b0;
        end
      end
    end else if (advance) begin
      for (int c = 0; c < NUM_CH; c++) begin
        last_set_r[c] <= last_set_nxt[c];
        seen_r[c]     <= seen_nxt[c];
        st_r[c]       <= st_nxt[c];
        for (int k = 0; k < NUM_TMR; k++) begin
          tmr_cnt_r[c][k] <= tmr_cnt_nxt[c][k];
          tmr_run_r[c][k] <= tmr_run_nxt[c][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_st_r[c] <= st_nxt[c];
      end
    end
  end

  assign out_valid           = out_vld_r;
  assign out_all_stable      = out_st_r[0].stable && out_st_r[1].stable;
  assign out_any_fault       = out_st_r[0].fault || out_st_r[1].fault;
  assign out_settled_one     = out_st_r[0].settled;
  assign out_stable_one      = out_st_r[0].stable;
  assign out_fault_one       = out_st_r[0].fault;
  assign out_warn_alarm_one  = out_st_r[0].warn_alarm;
  assign out_fault_alarm_one = out_st_r[0].fault_alarm;
  assign out_settled_two     = out_st_r[1].settled;
  assign out_stable_two      = out_st_r[1].stable;
  assign out_fault_two       = out_st_r[1].fault;
  assign out_warn_alarm_two  = out_st_r[1].warn_alarm;
  assign out_fault_alarm_two = out_st_r[1].fault_alarm;

  // alarm pulses only come with a fault state
  a_alarm_implies_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_warn_alarm_one || out_fault_alarm_one) |-> out_fault_one)
    else $error("channel one alarm without fault");

  // stable and fault are exclusive, both need the settle wait done
  a_state_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_stable_two && out_fault_two) &&
                  (out_settled_two || (!out_stable_two && !out_fault_two)))
    else $error("channel two state inconsistent");

  // channel one timeout and channel two stable timers never pass the saturation point
  a_timer_sat: assert property (@(posedge clk) disable iff (!rst_n)
    tmr_cnt_r[0][TMR_TOUT] <= TMR_MAX && tmr_cnt_r[1][TMR_STABLE] <= TMR_MAX)
    else $error("timer above limit");

  // channel one status and channel two last setpoint move only when a word is evaluated
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r[0]) && $stable(last_set_r[1]))
    else $error("state changed without a word");

endmodule
